/* rtl/tvsp_pkg.sv */
// shared types and constants for the tlv variant stream parser
package tvsp_pkg;

  // default number of field slots per variant
  localparam int MAX_FIELDS_DEF = 16;

  // result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int LVL_W    = $clog2(RQ_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_DISPLAY_ID = 1'b0;
  localparam logic CFG_GROUP_ID   = 1'b1;

  typedef enum logic [2:0] {
    EV_VARIANT   = 3'd0,
    EV_FIELD     = 3'd1,
    EV_GROUP     = 3'd2,
    EV_DROPPED   = 3'd3,
    EV_OUTSIDE   = 3'd4,
    EV_END_CLEAN = 3'd5,
    EV_END_TRUNC = 3'd6
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  entry_id;
    logic [15:0] entry_length;
    logic [31:0] value_offset;
    logic [15:0] variant_number;
    logic [3:0]  slot_number;
    logic [15:0] group_number;
    logic        last_result;
  } event_t;

  // up to two results caused by one byte, entry event first
  typedef struct packed {
    logic   v0;
    event_t e0;
    logic   v1;
    event_t e1;
  } res_pair_t;

  typedef struct packed {
    logic expecting_id;
    logic inside_variant;
  } parse_status_t;

endpackage

/* rtl/tvsp_parser.sv */
// byte-wise tlv phase machine, entry classification and end events
module tvsp_parser import tvsp_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          final_byte,
  input  logic [7:0]    display_id,
  input  logic [7:0]    grp_field_id,
  output res_pair_t     res,
  output parse_status_t status
);

  localparam int SW = $clog2(MAX_FIELDS + 1);

  typedef enum logic [1:0] {
    PH_ID     = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_VALUE  = 2'd3
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    cur_id, cur_id_next;
  logic [15:0]   cur_len, cur_len_next;
  logic [15:0]   remaining, remaining_next;
  logic [31:0]   byte_pos, byte_pos_next;
  logic          in_var, in_var_next;
  logic [15:0]   var_cnt, var_cnt_next;
  logic [SW-1:0] slots, slots_next;
  logic [7:0]    ghb, ghb_next;

  logic          done;
  logic [7:0]    last_b;
  logic [15:0]   rem_dec;
  event_t        ev0, ev1;

  always_comb begin
    phase_next     = phase;
    cur_id_next    = cur_id;
    cur_len_next   = cur_len;
    remaining_next = remaining;
    in_var_next    = in_var;
    var_cnt_next   = var_cnt;
    slots_next     = slots;
    ghb_next       = ghb;
    byte_pos_next  = byte_pos + 32'd1;
    done           = 1'b0;
    last_b         = 8'h00;
    rem_dec        = remaining;

    case (phase)
      PH_ID: begin
        cur_id_next = data_byte;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len_next = {8'h00, data_byte};
        phase_next   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len_next   = {data_byte, cur_len[7:0]};
        remaining_next = {data_byte, cur_len[7:0]};
        if ({data_byte, cur_len[7:0]} == 16'h0000) begin
          done       = 1'b1;
          phase_next = PH_ID;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (remaining == cur_len) ghb_next = data_byte;
        if (remaining != 16'h0000) rem_dec = remaining - 16'd1;
        remaining_next = rem_dec;
        if (rem_dec == 16'h0000) begin
          done       = 1'b1;
          last_b     = data_byte;
          phase_next = PH_ID;
        end
      end
      default: begin
        phase_next = PH_ID;
      end
    endcase

    // entry event, classified once its last byte is in
    ev0.kind           = EV_OUTSIDE;
    ev0.entry_id       = cur_id;
    ev0.entry_length   = cur_len_next;
    ev0.value_offset   = byte_pos + 32'd1 - {16'h0000, cur_len_next};
    ev0.variant_number = 16'h0000;
    ev0.slot_number    = 4'h0;
    ev0.group_number   = 16'h0000;
    ev0.last_result    = ~final_byte;

    if (cur_id == display_id) begin
      ev0.kind = EV_VARIANT;
      if (done) begin
        if (in_var) begin
          if (var_cnt != 16'hFFFF) var_cnt_next = var_cnt + 16'd1;
        end else begin
          var_cnt_next = 16'h0000;
        end
        in_var_next = 1'b1;
        slots_next  = '0;
      end
      ev0.variant_number = var_cnt_next;
    end else if (!in_var) begin
      ev0.kind = EV_OUTSIDE;
    end else if (grp_field_id != 8'h00 && cur_id == grp_field_id &&
                 cur_len_next == 16'd2) begin
      ev0.kind           = EV_GROUP;
      ev0.variant_number = var_cnt;
      ev0.group_number   = {ghb_next, last_b};
    end else if (slots < SW'(MAX_FIELDS)) begin
      ev0.kind           = EV_FIELD;
      ev0.variant_number = var_cnt;
      ev0.slot_number    = 4'(slots);
      if (done) slots_next = slots + SW'(1);
    end else begin
      ev0.kind           = EV_DROPPED;
      ev0.variant_number = var_cnt;
    end

    // end-of-buffer event
    ev1.kind           = (phase_next == PH_ID) ? EV_END_CLEAN : EV_END_TRUNC;
    ev1.entry_id       = 8'h00;
    ev1.entry_length   = 16'h0000;
    ev1.value_offset   = byte_pos + 32'd1;
    ev1.variant_number = in_var_next ? var_cnt_next : 16'h0000;
    ev1.slot_number    = 4'h0;
    ev1.group_number   = 16'h0000;
    ev1.last_result    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && final_byte)) begin
      phase     <= PH_ID;
      cur_id    <= 8'h00;
      cur_len   <= 16'h0000;
      remaining <= 16'h0000;
      byte_pos  <= 32'h0;
      in_var    <= 1'b0;
      var_cnt   <= 16'h0000;
      slots     <= '0;
      ghb       <= 8'h00;
    end else if (take) begin
      phase     <= phase_next;
      cur_id    <= cur_id_next;
      cur_len   <= cur_len_next;
      remaining <= remaining_next;
      byte_pos  <= byte_pos_next;
      in_var    <= in_var_next;
      var_cnt   <= var_cnt_next;
      slots     <= slots_next;
      ghb       <= ghb_next;
    end
  end

  assign res.v0 = take & done;
  assign res.e0 = ev0;
  assign res.v1 = take & final_byte;
  assign res.e1 = ev1;

  assign status.expecting_id   = (phase == PH_ID);
  assign status.inside_variant = in_var;

endmodule

/* rtl/tvsp_rq.sv */
// small result queue taking up to two results per cycle
module tvsp_rq import tvsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  res_pair_t        push,
  input  logic             pop,
  output event_t           head,
  output logic             head_valid,
  output logic [LVL_W-1:0] level
);

  event_t           mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RQ_AW-1:0] wr_alt;

  // second result lands behind the first when both are present
  assign wr_alt = wr_ptr + RQ_AW'(push.v0);

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.e0;
    if (push.v1) mem[wr_alt] <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push.v0) + RQ_AW'(push.v1);
      if (pop) rd_ptr <= rd_ptr + RQ_AW'(1);
      level  <= level + LVL_W'(push.v0) + LVL_W'(push.v1) - LVL_W'(pop);
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (level != '0);

endmodule

/* rtl/tlv_variant_stream_parser.sv */
// top level of the tlv variant stream parser: config registers, parser, result queue
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | sink      | in_valid/in_stall  | data_byte, final_byte
//  out     | source    | out_valid/out_stall| event_kind .. group_number, last_result
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a byte is parsed in the cycle it is taken
//   and its results (zero, one or two) sit in a four-entry queue from the next cycle
// in_stall rises when the queue holds more than two results, so one result
//   per cycle drained keeps bytes flowing with no gaps
// rst is synchronous; it clears the phase machine, counters, queue and config
// a final byte returns the parser to its reset state after the end event
module tlv_variant_stream_parser import tvsp_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  // result requests out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [7:0]  entry_id,
  output logic [15:0] entry_length,
  output logic [31:0] value_offset,
  output logic [15:0] variant_number,
  output logic [3:0]  slot_number,
  output logic [15:0] group_number,
  output logic        last_result,
  // register writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic             in_take;
  logic             out_take;
  logic [7:0]       display_id;
  logic [7:0]       grp_field_id;
  res_pair_t        res;
  parse_status_t    status;
  event_t           head;
  logic [LVL_W-1:0] level;

  // configuration, to be written only while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      display_id   <= 8'h00;
      grp_field_id <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISPLAY_ID: display_id   <= cfg_data;
        CFG_GROUP_ID:   grp_field_id <= cfg_data;
        default:        ;
      endcase
    end
  end

  // room for the worst case of two results from one byte
  assign in_stall = (level > LVL_W'(RQ_DEPTH - 2));
  assign in_take  = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;

  tvsp_parser #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (in_take),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .display_id   (display_id),
    .grp_field_id (grp_field_id),
    .res          (res),
    .status       (status)
  );

  tvsp_rq u_rq (
    .clk        (clk),
    .rst        (rst),
    .push       (res),
    .pop        (out_take),
    .head       (head),
    .head_valid (out_valid),
    .level      (level)
  );

  // result fields straight from the queue head
  assign event_kind     = head.kind;
  assign entry_id       = head.entry_id;
  assign entry_length   = head.entry_length;
  assign value_offset   = head.value_offset;
  assign variant_number = head.variant_number;
  assign slot_number    = head.slot_number;
  assign group_number   = head.group_number;
  assign last_result    = head.last_result;

`ifndef ASSERT_OFF
  // the final byte always leaves at least its end event queued
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_take && final_byte |=> out_valid)
    else $error("final byte produced no queued result");

  // parser is back at reset state after a final byte
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    in_take && final_byte |=> status.expecting_id && !status.inside_variant)
    else $error("parser state not cleared after final byte");

  // a result that is not the last of its byte has its partner queued behind it
  a_pair_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> level >= LVL_W'(2))
    else $error("first result of a pair queued without its partner");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(RQ_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

/* dv/tvsp_checker.sv */
// checker for the tlv variant stream parser: predicts result requests and compares them
module tvsp_checker import tvsp_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  event_kind,
  input  logic [7:0]  entry_id,
  input  logic [15:0] entry_length,
  input  logic [31:0] value_offset,
  input  logic [15:0] variant_number,
  input  logic [3:0]  slot_number,
  input  logic [15:0] group_number,
  input  logic        last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          events_pending
);

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_VALUE
  } tlv_phase_t;

  logic [7:0]  display_id_q;
  logic [7:0]  grp_field_id_q;
  tlv_phase_t  phase;
  logic [7:0]  cur_id;
  logic [15:0] cur_len;
  logic [15:0] remaining;
  logic [31:0] position;
  logic        inside_var;
  logic [15:0] variant_idx;
  int          slots_used;
  logic [7:0]  group_hi;
  event_t      expected_events[$];

  function automatic event_t make_event(event_kind_t kind, logic [7:0] id, logic [15:0] len,
                                        logic [31:0] off, logic [15:0] vnum,
                                        logic [3:0] slot, logic [15:0] grp);
    event_t ev;
    ev.kind           = kind;
    ev.entry_id       = id;
    ev.entry_length   = len;
    ev.value_offset   = off;
    ev.variant_number = vnum;
    ev.slot_number    = slot;
    ev.group_number   = grp;
    ev.last_result    = 1'b0;
    return ev;
  endfunction

  function automatic void clear_parse();
    phase       = PH_ID;
    cur_id      = '0;
    cur_len     = '0;
    remaining   = '0;
    position    = '0;
    inside_var  = 1'b0;
    variant_idx = '0;
    slots_used  = 0;
    group_hi    = '0;
  endfunction

  // classify a completed entry and update the variant bookkeeping
  function automatic event_t close_entry(logic [7:0] last_b, logic [31:0] pos);
    logic [31:0] off;
    event_t      ev;
    off = pos + 32'd1 - {16'd0, cur_len};
    if (cur_id == display_id_q) begin
      if (!inside_var) begin
        variant_idx = '0;
      end else if (variant_idx != 16'hFFFF) begin
        variant_idx = variant_idx + 16'd1;
      end
      inside_var = 1'b1;
      slots_used = 0;
      ev = make_event(EV_VARIANT, cur_id, cur_len, off, variant_idx, 4'd0, 16'd0);
    end else if (!inside_var) begin
      ev = make_event(EV_OUTSIDE, cur_id, cur_len, off, 16'd0, 4'd0, 16'd0);
    end else if (grp_field_id_q != 8'd0 && cur_id == grp_field_id_q && cur_len == 16'd2) begin
      ev = make_event(EV_GROUP, cur_id, cur_len, off, variant_idx, 4'd0, {group_hi, last_b});
    end else if (slots_used < MAX_FIELDS) begin
      ev = make_event(EV_FIELD, cur_id, cur_len, off, variant_idx, 4'(slots_used), 16'd0);
      slots_used++;
    end else begin
      ev = make_event(EV_DROPPED, cur_id, cur_len, off, variant_idx, 4'd0, 16'd0);
    end
    return ev;
  endfunction

  // advance the parser by one byte and queue the result requests it causes
  function automatic void predict_byte(logic [7:0] b, logic fin);
    event_t      ev[2];
    int          n;
    logic [31:0] pos;
    event_kind_t end_kind;
    n   = 0;
    pos = position;
    case (phase)
      PH_ID: begin
        cur_id = b;
        phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'd0, b};
        phase   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len[15:8] = b;
        remaining     = cur_len;
        if (cur_len == 16'd0) begin
          ev[n] = close_entry(8'd0, pos);
          n++;
          phase = PH_ID;
        end else begin
          phase = PH_VALUE;
        end
      end
      default: begin
        if (remaining == cur_len) group_hi = b;
        if (remaining != 16'd0) remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          ev[n] = close_entry(b, pos);
          n++;
          phase = PH_ID;
        end
      end
    endcase
    position = pos + 32'd1;
    if (fin) begin
      if (phase == PH_ID) end_kind = EV_END_CLEAN;
      else end_kind = EV_END_TRUNC;
      ev[n] = make_event(end_kind, 8'd0, 16'd0, position,
                         inside_var ? variant_idx : 16'd0, 4'd0, 16'd0);
      n++;
      clear_parse();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) ev[i].last_result = 1'b1;
      expected_events.push_back(ev[i]);
    end
  endfunction

  function automatic void check_event();
    event_t exp_ev;
    logic   bad;
    if (expected_events.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected result request: kind %0d id %h len %h off %h",
                 event_kind, entry_id, entry_length, value_offset);
      end
      mismatches++;
    end else begin
      exp_ev = expected_events.pop_front();
      bad = (event_kind !== exp_ev.kind) || (entry_id !== exp_ev.entry_id) ||
            (entry_length !== exp_ev.entry_length) ||
            (value_offset !== exp_ev.value_offset) ||
            (variant_number !== exp_ev.variant_number) ||
            (slot_number !== exp_ev.slot_number) ||
            (group_number !== exp_ev.group_number) ||
            (last_result !== exp_ev.last_result);
      if (bad) begin
        if (mismatches < 10) begin
          $display("mismatch exp: kind %0d id %h len %h off %h var %h slot %h grp %h last %b",
                   exp_ev.kind, exp_ev.entry_id, exp_ev.entry_length, exp_ev.value_offset,
                   exp_ev.variant_number, exp_ev.slot_number, exp_ev.group_number,
                   exp_ev.last_result);
          $display("         got: kind %0d id %h len %h off %h var %h slot %h grp %h last %b",
                   event_kind, entry_id, entry_length, value_offset, variant_number,
                   slot_number, group_number, last_result);
        end
        mismatches++;
      end
    end
  endfunction

  // bytes are predicted before results are compared, so a same-edge pair stays in order
  always @(posedge clk) begin
    if (rst) begin
      display_id_q   = '0;
      grp_field_id_q = '0;
      clear_parse();
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DISPLAY_ID) display_id_q = cfg_data;
        else grp_field_id_q = cfg_data;
      end
      if (in_valid && !in_stall) predict_byte(data_byte, final_byte);
      if (out_valid && !out_stall) check_event();
    end
    events_pending = expected_events.size();
  end

endmodule

/* dv/tb.sv */
// testbench top for the tlv variant stream parser: stimulus, back-pressure and verdict
module tb import tvsp_pkg::*;;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_kind;
  logic [7:0]  entry_id;
  logic [15:0] entry_length;
  logic [31:0] value_offset;
  logic [15:0] variant_number;
  logic [3:0]  slot_number;
  logic [15:0] group_number;
  logic        last_result;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int events_pending;

  // idle percentages for each side, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;

  // current register values, used to bias the ids in generated buffers
  logic [7:0] disp_cfg;
  logic [7:0] group_cfg;

  // tlv buffer under construction
  logic [7:0] buffer_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tlv_variant_stream_parser DUT (.*);

  tvsp_checker u_checker (.*);

  // receiver side: random stall, or a long hold-off while the sender keeps pushing
  initial begin
    int holds_served;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        // long enough for the result queue to fill and the input to stall
        for (int k = 0; k < 80; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // safety net for a hung handshake
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // offer one byte; returns at the falling edge after acceptance with valid still high,
  // so back-to-back bytes never lower and raise valid in the same step
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // send the built buffer, final flag on its last byte
  task automatic send_buffer();
    for (int i = 0; i < buffer_bytes.size(); i++) begin
      send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    end
    buffer_bytes.delete();
  endtask

  // registers change only with the parser idle
  task automatic set_config(input logic [7:0] disp, input logic [7:0] grp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DISPLAY_ID;
    cfg_data  <= disp;
    @(negedge clk);
    cfg_index <= CFG_GROUP_ID;
    cfg_data  <= grp;
    @(negedge clk);
    cfg_we    <= 1'b0;
    disp_cfg  = disp;
    group_cfg = grp;
  endtask

  // drop valid, let every expected result drain, then a few cycles of slack
  task automatic finish_phase();
    in_valid <= 1'b0;
    wait (events_pending == 0);
    repeat (4) @(negedge clk);
  endtask

  // opening entries lean on the display id, interior ones pick it rarely
  function automatic logic [7:0] pick_id(input int role);
    int r;
    r = $urandom_range(99);
    if (role == 1 && r < 75) return disp_cfg;
    if (role == 0 && r < 12) return disp_cfg;
    if (r < 30) return group_cfg;
    if (r < 38) return 8'h00;
    if (r < 45) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_len(input logic [7:0] id);
    int r;
    r = $urandom_range(99);
    if (id == group_cfg && r < 70) return 16'd2;
    if (r < 35) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 4));
    if (r < 97) return 16'($urandom_range(5, 24));
    return 16'($urandom_range(25, 300));
  endfunction

  function automatic void add_entry(input logic [7:0] id, input logic [15:0] len);
    buffer_bytes.push_back(id);
    buffer_bytes.push_back(len[7:0]);
    buffer_bytes.push_back(len[15:8]);
    for (int i = 0; i < len; i++) buffer_bytes.push_back(8'($urandom));
  endfunction

  // corner cases: entry before any variant, zero length, one-byte value, group set,
  // group id with the wrong length, a second variant, entry and end on one byte,
  // and ends inside a partial entry
  task automatic send_directed();
    buffer_bytes = '{8'h07, 8'h00, 8'h00,
                     8'h01, 8'h01, 8'h00, 8'hFF,
                     8'h02, 8'h02, 8'h00, 8'hAB, 8'hCD,
                     8'h02, 8'h01, 8'h00, 8'h55,
                     8'h01, 8'h00, 8'h00,
                     8'hFF, 8'h00, 8'h00};
    send_buffer();
    // length 0xffff, cut after one value byte
    buffer_bytes = '{8'h10, 8'hFF, 8'hFF, 8'h00};
    send_buffer();
    // buffer of a single id byte
    buffer_bytes = '{8'h01};
    send_buffer();
  endtask

  // mostly well-formed buffers, some dense enough to run out of slots,
  // some cut inside a last entry, and a little line noise
  task automatic send_random(input int budget);
    int          sent;
    int          pick;
    int          entries;
    int          cut;
    logic        dense;
    logic [7:0]  id;
    logic [15:0] len;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom));
      end else begin
        dense   = ($urandom_range(3) == 0);
        entries = dense ? $urandom_range(17, 22) : $urandom_range(1, 12);
        for (int e = 0; e < entries; e++) begin
          id = pick_id(e == 0 ? 1 : (dense ? 2 : 0));
          add_entry(id, pick_len(id));
        end
        if (pick < 28) begin
          // partial entry at the end of the buffer
          cut = $urandom_range(3);
          len = 16'($urandom);
          buffer_bytes.push_back(pick_id(0));
          if (cut > 0) buffer_bytes.push_back(len[7:0]);
          if (cut > 1) buffer_bytes.push_back(len[15:8]);
          if (cut > 2) repeat ($urandom_range(1, 5)) buffer_bytes.push_back(8'($urandom));
        end
      end
      sent += buffer_bytes.size();
      send_buffer();
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = '0;
    final_byte = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DISPLAY_ID;
    cfg_data   = '0;
    disp_cfg   = '0;
    group_cfg  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    send_idle_pct = 24;
    recv_idle_pct = 68;
    set_config(8'h01, 8'h02);
    send_directed();
    send_random(50);
    finish_phase();

    // id zero opens variants, group numbers disabled
    set_config(8'h00, 8'h00);
    send_random(50);
    finish_phase();

    // sender idles a lot, receiver a little
    send_idle_pct = 68;
    recv_idle_pct = 24;
    // display id equal to group id: such entries open variants
    set_config(8'hFF, 8'hFF);
    send_random(50);
    finish_phase();

    set_config(8'h80, 8'hFF);
    send_random(50);
    finish_phase();

    // no idling; one long receiver hold-off fills the queue and stalls the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(8'h3C, 8'h01);
    hold_requests++;
    send_random(50);

    in_valid <= 1'b0;
    for (int k = 0; k < 4000 && events_pending != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && events_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
